@@ sv/rse_pkg.sv @@
// ---------------------------------------------------------------------------
// rse_pkg
// Shared types and codes of the postfix stack evaluator: token kinds,
// operator codes, status codes, sequencer states and the ALU handshake.
// ---------------------------------------------------------------------------
package rse_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned OP_W     = 3;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned DEPTH_W  = 5;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH   = 2'd0,
		FN_APPLY  = 2'd1,
		FN_FINISH = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [OP_W-1:0] {
		OP_SUB = 3'd0,
		OP_ADD = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4,
		OP_POW = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_UNDER  = 3'd1,
		ST_OVER   = 3'd2,
		ST_DIVZ   = 3'd3,
		ST_NEGEXP = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DONE
	} seq_state_t;

	typedef enum logic [2:0] {
		ALU_IDLE,
		ALU_DIV,
		ALU_SIGN,
		ALU_POW,
		ALU_DONE
	} alu_state_t;

	typedef struct packed {
		logic            start;
		logic [OP_W-1:0] op;
	} alu_req_t;

	typedef struct packed {
		logic    done;
		status_t status;
	} alu_rsp_t;

endpackage

@@ sv/rse_in_if.sv @@
// ---------------------------------------------------------------------------
// rse_in_if
// Token channel: valid/ready handshake carrying one postfix token.
// ---------------------------------------------------------------------------
interface rse_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [31:0] number;
	logic [2:0]         operator;

	modport source(output valid, func, number, operator, input ready);
	modport sink(input valid, func, number, operator, output ready);
endinterface

@@ sv/rse_out_if.sv @@
// ---------------------------------------------------------------------------
// rse_out_if
// Result channel: valid/ready handshake carrying one evaluation result.
// ---------------------------------------------------------------------------
interface rse_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] top_value;
	logic [4:0]         stack_depth;
	logic [2:0]         status;
	logic               finished;

	modport source(output valid, top_value, stack_depth, status, finished, input ready);
	modport sink(input valid, top_value, stack_depth, status, finished, output ready);
endinterface

@@ sv/rse_stack.sv @@
// ---------------------------------------------------------------------------
// rse_stack
// Operand stack storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module rse_stack
	import rse_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/rse_alu.sv @@
// ---------------------------------------------------------------------------
// rse_alu
// Shared arithmetic unit: add and subtract in one step, restoring division
// one quotient bit per cycle, multiply and power by square-and-multiply.
// ---------------------------------------------------------------------------
module rse_alu
	import rse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  alu_req_t          req,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output alu_rsp_t          rsp,
	output logic [DATA_W-1:0] result
);

	alu_state_t state_q, state_d;

	logic [DATA_W-1:0] res_q;
	status_t           status_q;
	logic [OP_W-1:0]   op_q;
	logic              qneg_q;
	logic              lneg_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [4:0]        cnt_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] base_q;
	logic [DATA_W-1:0] exp_q;

	logic [DATA_W-1:0] lmag, rmag;
	logic [DATA_W:0]   rem_sh, diff;
	logic [2*DATA_W-1:0] acc_prod, base_prod;

	assign lmag      = left[DATA_W-1]  ? (DATA_W'(0) - left)  : left;
	assign rmag      = right[DATA_W-1] ? (DATA_W'(0) - right) : right;
	assign rem_sh    = {rem_q, quo_q[DATA_W-1]};
	assign diff      = rem_sh - {1'b0, dvs_q};
	assign acc_prod  = acc_q * base_q;
	assign base_prod = base_q * base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ALU_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ALU_IDLE: begin
				if (req.start) begin
					case (op_t'(req.op))
						OP_MUL: state_d = ALU_POW;
						OP_DIV, OP_MOD: state_d = (right == '0) ? ALU_DONE : ALU_DIV;
						OP_POW: state_d = right[DATA_W-1] ? ALU_DONE : ALU_POW;
						default: state_d = ALU_DONE;
					endcase
				end
			end
			ALU_DIV: begin
				if (cnt_q == 5'd31) begin
					state_d = ALU_SIGN;
				end
			end
			ALU_SIGN: state_d = ALU_DONE;
			ALU_POW: begin
				if (exp_q == '0) begin
					state_d = ALU_DONE;
				end
			end
			ALU_DONE: state_d = ALU_IDLE;
			default: state_d = ALU_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ALU_IDLE: begin
				if (req.start) begin
					op_q     <= req.op;
					status_q <= ST_OK;
					qneg_q   <= left[DATA_W-1] ^ right[DATA_W-1];
					lneg_q   <= left[DATA_W-1];
					case (op_t'(req.op))
						OP_SUB: res_q <= left - right;
						OP_ADD: res_q <= left + right;
						OP_MUL: begin
							// single step of the power loop: acc * base with exponent one
							acc_q  <= right;
							base_q <= left;
							exp_q  <= DATA_W'(1);
						end
						OP_DIV, OP_MOD: begin
							if (right == '0) begin
								status_q <= ST_DIVZ;
							end
							rem_q <= '0;
							quo_q <= lmag;
							dvs_q <= rmag;
							cnt_q <= '0;
						end
						OP_POW: begin
							if (right[DATA_W-1]) begin
								status_q <= ST_NEGEXP;
							end
							acc_q  <= DATA_W'(1);
							base_q <= left;
							exp_q  <= right;
						end
						default: res_q <= '0;
					endcase
				end
			end
			ALU_DIV: begin
				cnt_q <= cnt_q + 5'd1;
				if (!diff[DATA_W]) begin
					rem_q <= diff[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b0};
				end
			end
			ALU_SIGN: begin
				if (op_t'(op_q) == OP_DIV) begin
					res_q <= qneg_q ? (DATA_W'(0) - quo_q) : quo_q;
				end else begin
					res_q <= lneg_q ? (DATA_W'(0) - rem_q) : rem_q;
				end
			end
			ALU_POW: begin
				if (exp_q == '0) begin
					res_q <= acc_q;
				end else begin
					if (exp_q[0]) begin
						acc_q <= acc_prod[DATA_W-1:0];
					end
					base_q <= base_prod[DATA_W-1:0];
					exp_q  <= exp_q >> 1;
				end
			end
			default: ;
		endcase
	end

	assign rsp.done   = (state_q == ALU_DONE);
	assign rsp.status = status_q;
	assign result     = res_q;

endmodule

@@ sv/rpn_stack_evaluator.sv @@
// ---------------------------------------------------------------------------
// rpn_stack_evaluator
// Postfix integer evaluator around an operand stack, one result per token.
// Flow: push, finish, no-op and operator underflow answer from the token; other
//   operators read the left operand off the stack into the ALU, which divides
//   bit by bit and runs multiply and power as a loop over the exponent bits.
// Throughput: one token at a time; the next token is taken in the cycle after
//   the result is loaded into the output register, which an output stall delays.
// Reset: arst_n clears the sequencer, the stack count and the output valid;
//   stack contents are left as they are and are never read before written.
// ---------------------------------------------------------------------------
module rpn_stack_evaluator
	import rse_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rse_in_if.sink      token,
	rse_out_if.source   result
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_C = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] TWO_C  = CW'(2);

	// Sequencer and stack bookkeeping
	seq_state_t        state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [DATA_W-1:0] top_q, top_d;
	logic [OP_W-1:0]   op_q;

	// Result waiting for the output register
	logic              pend_upd;
	logic [DATA_W-1:0] pend_value_q, pend_value_d;
	status_t           pend_status_q, pend_status_d;
	logic              pend_fin_q, pend_fin_d;

	// Output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic [DEPTH_W-1:0] out_depth_q;
	status_t           out_status_q;
	logic              out_fin_q;
	logic              load_out;

	// Stack port and ALU handshake
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [DATA_W-1:0] wr_data, rd_data;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [DATA_W-1:0] alu_result;

	logic              tok_acc;
	logic [CW-1:0]     cnt_m2;
	logic [DATA_W-1:0] top_or_zero;
	logic [CW+DEPTH_W-1:0] depth_ext;

	assign token.ready = (state_q == S_IDLE);
	assign tok_acc     = token.valid && token.ready;
	assign cnt_m2      = count_q - TWO_C;
	assign top_or_zero = (count_q != '0) ? top_q : '0;
	// stack depth is reported modulo 32
	assign depth_ext   = {{DEPTH_W{1'b0}}, count_q};

	rse_stack #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// left operand comes straight off the stack read, right operand is the cached top
	rse_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.left  (rd_data),
		.right (top_q),
		.rsp   (alu_rsp),
		.result(alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		top_d         = top_q;
		wr_en         = 1'b0;
		wr_addr       = count_q[AW-1:0];
		wr_data       = token.number;
		rd_en         = 1'b0;
		rd_addr       = cnt_m2[AW-1:0];
		alu_req       = '0;
		pend_upd      = 1'b0;
		pend_value_d  = pend_value_q;
		pend_status_d = pend_status_q;
		pend_fin_d    = 1'b0;
		load_out      = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (tok_acc) begin
					pend_upd      = 1'b1;
					pend_status_d = ST_OK;
					pend_value_d  = top_or_zero;
					state_d       = S_DONE;
					case (func_t'(token.func))
						FN_PUSH: begin
							if (count_q == FULL_C) begin
								pend_status_d = ST_OVER;
							end else begin
								// write the new entry and cache it as top
								wr_en        = 1'b1;
								count_d      = count_q + CW'(1);
								top_d        = token.number;
								pend_value_d = token.number;
							end
						end
						FN_APPLY: begin
							if (count_q < TWO_C) begin
								pend_status_d = ST_UNDER;
							end else begin
								// fetch the left operand, hold the result slot for the ALU
								pend_upd = 1'b0;
								rd_en    = 1'b1;
								state_d  = S_READ;
							end
						end
						FN_FINISH: begin
							if (count_q == '0) begin
								pend_status_d = ST_UNDER;
							end else begin
								// pop the final value and drop the rest of the stack
								pend_fin_d = 1'b1;
								count_d    = '0;
							end
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				alu_req.start = 1'b1;
				alu_req.op    = op_q;
				state_d       = S_EXEC;
			end
			S_EXEC: begin
				if (alu_rsp.done) begin
					pend_upd      = 1'b1;
					pend_status_d = alu_rsp.status;
					pend_value_d  = top_q;
					state_d       = S_DONE;
					if (alu_rsp.status == ST_OK) begin
						// replace the left operand with the result, drop the right one
						wr_en        = 1'b1;
						wr_addr      = cnt_m2[AW-1:0];
						wr_data      = alu_result;
						top_d        = alu_result;
						count_d      = count_q - CW'(1);
						pend_value_d = alu_result;
					end
				end
			end
			S_DONE: begin
				// hand over once the output register is free or being emptied
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (tok_acc) begin
			op_q <= token.operator;
		end
		if (pend_upd) begin
			pend_value_q  <= pend_value_d;
			pend_status_q <= pend_status_d;
			pend_fin_q    <= pend_fin_d;
		end
		if (load_out) begin
			out_value_q  <= pend_value_q;
			out_depth_q  <= depth_ext[DEPTH_W-1:0];
			out_status_q <= pend_status_q;
			out_fin_q    <= pend_fin_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.top_value   = out_value_q;
	assign result.stack_depth = out_depth_q;
	assign result.status      = out_status_q;
	assign result.finished    = out_fin_q;

endmodule
